@@ design/stable_priority_queue_defines.svh @@
// assertion macros for the rtl, included by spq_back
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

// condition holds at every edge out of reset
`define SPQ_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("spq invariant violated");

// consequence in the cycle after the antecedent
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spq sequencing violated");

`endif

@@ design/spq_pkg.sv @@
package spq_pkg;

  localparam int ENTRIES  = 64;
  localparam int LEVELS   = 16;
  localparam int Q_DEPTH  = 2;

  localparam int PRIO_W   = 4;
  localparam int HANDLE_W = 32;
  localparam int STAT_W   = 2;
  localparam int OCC_W    = 7;

  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int LVL_W    = $clog2(LEVELS);
  localparam int QP_W     = $clog2(Q_DEPTH);
  localparam int QC_W     = $clog2(Q_DEPTH + 1);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    BK_ISSUE  = 1'b0,
    BK_COMMIT = 1'b1
  } back_state_e;

  typedef struct packed {
    opcode_e             op;
    logic [LVL_W-1:0]    level;
    logic [HANDLE_W-1:0] handle;
  } cmd_t;

  // lowest set bit of the non-empty map
  function automatic logic [LVL_W-1:0] lowest_level(input logic [LEVELS-1:0] bits);
    logic [LVL_W-1:0] idx;
    idx = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (bits[i]) begin
        idx = LVL_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

@@ design/spq_if.sv @@
interface spq_req_if import spq_pkg::*;;
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [PRIO_W-1:0]   priority_req;
  logic [HANDLE_W-1:0] event_handle;

  modport source (output valid, output opcode, output priority_req, output event_handle,
                  input ready);
  modport sink   (input valid, input opcode, input priority_req, input event_handle,
                  output ready);
endinterface

interface spq_rsp_if import spq_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [HANDLE_W-1:0] popped_handle;
  logic [PRIO_W-1:0]   popped_priority;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, output status, output popped_handle, output popped_priority,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input popped_handle, input popped_priority,
                  input occupancy, output ready);
endinterface

@@ design/spq_ram.sv @@
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/spq_front.sv @@
module spq_front import spq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  spq_req_if.sink    req_i,
  output logic       cmd_valid_o,
  input  logic       cmd_ready_i,
  output cmd_t       cmd_o
);

  cmd_t             slot_q [Q_DEPTH];
  logic [QP_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QP_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QC_W-1:0]  fill_q, fill_d;
  logic             push, pop;
  cmd_t             cmd_in;

  // classify and clamp the level
  always_comb begin
    cmd_in.op     = opcode_e'(req_i.opcode);
    cmd_in.handle = req_i.event_handle;
    if (32'(req_i.priority_req) >= LEVELS) begin
      cmd_in.level = LVL_W'(LEVELS - 1);
    end else begin
      cmd_in.level = LVL_W'(req_i.priority_req);
    end
  end

  assign req_i.ready = (fill_q != QC_W'(Q_DEPTH));
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign push        = req_i.valid && req_i.ready;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QP_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QP_W'(1) : rd_ptr_q;
    fill_d   = fill_q + QC_W'(push) - QC_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

@@ design/spq_back.sv @@
`include "stable_priority_queue_defines.svh"

module spq_back import spq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  output logic       cmd_ready_o,
  input  cmd_t       cmd_i,
  spq_rsp_if.source  rsp_o
);

  back_state_e         st_q, st_d;
  logic [LEVELS-1:0]   nonempty_q, nonempty_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    fs_cnt_q, fs_cnt_d;
  logic [CNT_W-1:0]    fresh_q, fresh_d;
  logic [IDX_W-1:0]    heads_q [LEVELS];
  logic [IDX_W-1:0]    tails_q [LEVELS];

  opcode_e             op_q;
  logic [LVL_W-1:0]    lvl_q;
  logic [HANDLE_W-1:0] handle_q;
  logic                reject_q;
  logic [IDX_W-1:0]    head_q;

  logic                out_valid_q, out_valid_d;
  status_e             out_status_q, out_status_d;
  logic [HANDLE_W-1:0] out_handle_q, out_handle_d;
  logic [PRIO_W-1:0]   out_prio_q, out_prio_d;
  logic [OCC_W-1:0]    out_occ_q, out_occ_d;

  logic                fire, commit;
  logic [LVL_W-1:0]    first_lvl;
  logic [IDX_W-1:0]    slot;
  logic                head_wr, tail_wr;
  logic [IDX_W-1:0]    head_wdata;

  logic                h_we, h_re, l_we, l_re, f_we, f_re;
  logic [IDX_W-1:0]    h_waddr, h_raddr, l_waddr, l_raddr, f_waddr, f_raddr;
  logic [IDX_W-1:0]    l_wdata, f_wdata, l_rdata, f_rdata;
  logic [HANDLE_W-1:0] h_rdata;

  spq_ram #(.WIDTH(HANDLE_W), .DEPTH(ENTRIES)) u_handles (
    .clk_i(clk_i), .we_i(h_we), .waddr_i(h_waddr), .wdata_i(handle_q),
    .re_i(h_re), .raddr_i(h_raddr), .rdata_o(h_rdata)
  );

  spq_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_links (
    .clk_i(clk_i), .we_i(l_we), .waddr_i(l_waddr), .wdata_i(l_wdata),
    .re_i(l_re), .raddr_i(l_raddr), .rdata_o(l_rdata)
  );

  spq_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_free (
    .clk_i(clk_i), .we_i(f_we), .waddr_i(f_waddr), .wdata_i(f_wdata),
    .re_i(f_re), .raddr_i(f_raddr), .rdata_o(f_rdata)
  );

  assign first_lvl   = lowest_level(nonempty_q);
  assign cmd_ready_o = (st_q == BK_ISSUE);
  assign fire        = cmd_valid_i && cmd_ready_o;
  assign commit      = (st_q == BK_COMMIT) && (!out_valid_q || rsp_o.ready);
  assign slot        = (fs_cnt_q != '0) ? f_rdata : fresh_q[IDX_W-1:0];

  // issue the reads
  always_comb begin
    h_re    = fire && (cmd_i.op == OP_POP);
    l_re    = h_re;
    h_raddr = heads_q[first_lvl];
    l_raddr = heads_q[first_lvl];
    f_re    = fire && (cmd_i.op == OP_INSERT);
    f_raddr = IDX_W'(fs_cnt_q - CNT_W'(1));
  end

  // commit and next state
  always_comb begin
    st_d         = st_q;
    nonempty_d   = nonempty_q;
    count_d      = count_q;
    fs_cnt_d     = fs_cnt_q;
    fresh_d      = fresh_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_handle_d = out_handle_q;
    out_prio_d   = out_prio_q;
    out_occ_d    = out_occ_q;
    head_wr      = 1'b0;
    tail_wr      = 1'b0;
    head_wdata   = slot;
    h_we         = 1'b0;
    h_waddr      = slot;
    l_we         = 1'b0;
    l_waddr      = tails_q[lvl_q];
    l_wdata      = slot;
    f_we         = 1'b0;
    f_waddr      = fs_cnt_q[IDX_W-1:0];
    f_wdata      = head_q;

    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (st_q)
      BK_ISSUE: begin
        if (fire) begin
          st_d = BK_COMMIT;
        end
      end
      BK_COMMIT: begin
        if (commit) begin
          st_d         = BK_ISSUE;
          out_valid_d  = 1'b1;
          out_status_d = STAT_OK;
          out_handle_d = '0;
          out_prio_d   = '0;
          if (reject_q) begin
            out_status_d = (op_q == OP_POP) ? STAT_EMPTY : STAT_FULL;
          end else if (op_q == OP_INSERT) begin
            h_we    = 1'b1;
            tail_wr = 1'b1;
            if (nonempty_q[lvl_q]) begin
              l_we = 1'b1;
            end else begin
              head_wr           = 1'b1;
              nonempty_d[lvl_q] = 1'b1;
            end
            if (fs_cnt_q != '0) begin
              fs_cnt_d = fs_cnt_q - CNT_W'(1);
            end else begin
              fresh_d = fresh_q + CNT_W'(1);
            end
            count_d = count_q + CNT_W'(1);
          end else begin
            out_handle_d = h_rdata;
            out_prio_d   = PRIO_W'(lvl_q);
            if (head_q == tails_q[lvl_q]) begin
              nonempty_d[lvl_q] = 1'b0;
            end else begin
              head_wr    = 1'b1;
              head_wdata = l_rdata;
            end
            f_we     = 1'b1;
            fs_cnt_d = fs_cnt_q + CNT_W'(1);
            count_d  = count_q - CNT_W'(1);
          end
          out_occ_d = OCC_W'(count_d);
        end
      end
      default: st_d = BK_ISSUE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= BK_ISSUE;
      nonempty_q  <= '0;
      count_q     <= '0;
      fs_cnt_q    <= '0;
      fresh_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      nonempty_q  <= nonempty_d;
      count_q     <= count_d;
      fs_cnt_q    <= fs_cnt_d;
      fresh_q     <= fresh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      op_q     <= cmd_i.op;
      handle_q <= cmd_i.handle;
      head_q   <= heads_q[first_lvl];
      if (cmd_i.op == OP_POP) begin
        lvl_q    <= first_lvl;
        reject_q <= (nonempty_q == '0);
      end else begin
        lvl_q    <= cmd_i.level;
        reject_q <= (count_q == CNT_W'(ENTRIES));
      end
    end
    if (head_wr) begin
      heads_q[lvl_q] <= head_wdata;
    end
    if (tail_wr) begin
      tails_q[lvl_q] <= slot;
    end
    out_status_q <= out_status_d;
    out_handle_q <= out_handle_d;
    out_prio_q   <= out_prio_d;
    out_occ_q    <= out_occ_d;
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.status          = out_status_q;
  assign rsp_o.popped_handle   = out_handle_q;
  assign rsp_o.popped_priority = out_prio_q;
  assign rsp_o.occupancy       = out_occ_q;

  `SPQ_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(ENTRIES))
  `SPQ_ASSERT_ALWAYS(a_free_balance, {1'b0, fs_cnt_q} + {1'b0, count_q} == {1'b0, fresh_q})
  `SPQ_ASSERT_ALWAYS(a_empty_map, (nonempty_q == '0) == (count_q == '0))
  `SPQ_ASSERT_NEXT(a_commit_out, commit, out_valid_q && (st_q == BK_ISSUE))

endmodule

@@ design/stable_priority_queue.sv @@
// channel  dir  role     payload
// req_i    in   sink     opcode, priority_req, event_handle
// rsp_o    out  source   status, popped_handle, popped_priority, occupancy
//
// each request passes through the execute states: an issue state that reads the handle,
// link and free-slot memories, then a commit state that writes them back and loads the
// result register; a two-entry request queue lets requests arrive while one executes
// reset empties the queue at once, no clearing pass (unused slots come from a fill count)
// a stalled result holds the execute stage; the request queue fills and then drops ready
module stable_priority_queue import spq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  spq_req_if.sink    req_i,
  spq_rsp_if.source  rsp_o
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  spq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  spq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .rsp_o       (rsp_o)
  );

endmodule

@@ test/spq_checker.sv @@
module spq_checker import spq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  spq_req_if   req_mon,
  spq_rsp_if   rsp_mon,
  output int   fail_count_o,
  output int   pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_e             status;
    logic [HANDLE_W-1:0] handle;
    logic [PRIO_W-1:0]   level;
    logic [OCC_W-1:0]    occupancy;
  } pop_outcome_t;

  logic [HANDLE_W-1:0] slot_handle [ENTRIES];
  logic [IDX_W-1:0]    slot_next   [ENTRIES];
  logic [IDX_W-1:0]    free_stack  [ENTRIES];
  logic [IDX_W-1:0]    level_head  [LEVELS];
  logic [IDX_W-1:0]    level_tail  [LEVELS];
  logic [LEVELS-1:0]   level_busy;
  int                  free_left;
  int                  queued;

  pop_outcome_t awaited_outcomes [$];
  int           mismatches;
  int           outstanding;

  assign fail_count_o    = mismatches;
  assign pending_count_o = outstanding;

  task automatic clear_queue_model();
    for (int i = 0; i < ENTRIES; i++) begin
      free_stack[i] = IDX_W'(i);
    end
    free_left  = ENTRIES;
    level_busy = '0;
    queued     = 0;
  endtask

  function automatic pop_outcome_t apply_request(opcode_e op, logic [PRIO_W-1:0] prio,
                                                  logic [HANDLE_W-1:0] handle);
    pop_outcome_t res;
    logic [IDX_W-1:0] s;
    int lv;
    int found;
    res.status = STAT_OK;
    res.handle = '0;
    res.level  = '0;
    lv = (int'(prio) >= LEVELS) ? LEVELS - 1 : int'(prio);
    if (op == OP_INSERT) begin
      if (free_left == 0) begin
        res.status = STAT_FULL;
      end else begin
        free_left--;
        s = free_stack[free_left];
        slot_handle[s] = handle;
        slot_next[s]   = '0;
        if (level_busy[lv]) begin
          slot_next[level_tail[lv]] = s;
          level_tail[lv] = s;
        end else begin
          level_head[lv] = s;
          level_tail[lv] = s;
          level_busy[lv] = 1'b1;
        end
        queued++;
      end
    end else begin
      found = -1;
      for (int i = 0; i < LEVELS && found < 0; i++) begin
        if (level_busy[i]) found = i;
      end
      if (found < 0) begin
        res.status = STAT_EMPTY;
      end else begin
        s = level_head[found];
        res.handle = slot_handle[s];
        res.level  = PRIO_W'(found);
        if (s == level_tail[found]) level_busy[found] = 1'b0;
        else level_head[found] = slot_next[s];
        free_stack[free_left] = s;
        free_left++;
        queued--;
      end
    end
    res.occupancy = OCC_W'(queued);
    return res;
  endfunction

  task automatic flag_mismatch(string what);
    mismatches++;
    if (mismatches <= 50) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  task automatic compare_result(pop_outcome_t exp);
    if (rsp_mon.status !== exp.status)
      flag_mismatch($sformatf("status %0d, expected %0d", rsp_mon.status, exp.status));
    if (rsp_mon.popped_handle !== exp.handle)
      flag_mismatch($sformatf("popped_handle %h, expected %h", rsp_mon.popped_handle,
                              exp.handle));
    if (rsp_mon.popped_priority !== exp.level)
      flag_mismatch($sformatf("popped_priority %0d, expected %0d", rsp_mon.popped_priority,
                              exp.level));
    if (rsp_mon.occupancy !== exp.occupancy)
      flag_mismatch($sformatf("occupancy %0d, expected %0d", rsp_mon.occupancy,
                              exp.occupancy));
  endtask

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // results are taken before requests so a stray result never matches a new request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_queue_model();
      awaited_outcomes.delete();
      outstanding <= 0;
    end else begin
      if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
        if (awaited_outcomes.size() == 0) flag_mismatch("result transfer with none awaited");
        else compare_result(awaited_outcomes.pop_front());
      end
      if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
        awaited_outcomes.push_back(apply_request(opcode_e'(req_mon.opcode),
                                                 req_mon.priority_req, req_mon.event_handle));
      end
      outstanding <= awaited_outcomes.size();
    end
  end

endmodule

@@ test/testbench.sv @@
module testbench import spq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i;
  logic rst_ni;
  int   fail_total;
  int   in_flight;
  int   idle_pct;
  int   stall_pct;
  int   hold_len;

  spq_req_if req_ch ();
  spq_rsp_if rsp_ch ();

  stable_priority_queue DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  spq_checker watcher (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_mon         (req_ch),
    .rsp_mon         (rsp_ch),
    .fail_count_o    (fail_total),
    .pending_count_o (in_flight)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // result side, long hold-offs counted here
  initial begin
    int hold_left;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_len > 0) begin
        hold_left = hold_len;
        hold_len  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_item(opcode_e op, logic [PRIO_W-1:0] prio, logic [HANDLE_W-1:0] handle);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid        <= 1'b1;
    req_ch.opcode       <= op;
    req_ch.priority_req <= prio;
    req_ch.event_handle <= handle;
    @(posedge clk_i);
    while (req_ch.ready !== 1'b1) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (in_flight != 0) @(posedge clk_i);
  endtask

  // bursts biased to inserts fill the store, bursts biased to pops empty it, mixed bursts sit between
  task automatic run_random(int count, int hold_at, int pause_at);
    int done;
    int burst;
    int ins_pct;
    int lvl_lo;
    int lvl_hi;
    bit first;
    opcode_e op;
    logic [HANDLE_W-1:0] h;
    done  = 0;
    first = 1'b1;
    while (done < count) begin
      burst = $urandom_range(80, 20);
      case ($urandom_range(3))
        0: ins_pct = 90;
        1: ins_pct = 50;
        2: ins_pct = 15;
        default: ins_pct = 65;
      endcase
      if (first) begin
        ins_pct = 95;
        burst   = 80;
        first   = 1'b0;
      end
      if ($urandom_range(1) == 1) begin
        lvl_lo = $urandom_range(LEVELS - 1);
        lvl_hi = (lvl_lo + 2 > LEVELS - 1) ? LEVELS - 1 : lvl_lo + 2;
      end else begin
        lvl_lo = 0;
        lvl_hi = LEVELS - 1;
      end
      for (int k = 0; k < burst && done < count; k++) begin
        op = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_POP;
        case ($urandom_range(9))
          0: h = '0;
          1: h = '1;
          default: h = $urandom();
        endcase
        send_item(op, PRIO_W'($urandom_range(lvl_hi, lvl_lo)), h);
        done++;
        if (done == hold_at) hold_len = 300;
        if (done == pause_at) wait_drained();
      end
    end
  endtask

  initial begin
    rst_ni                  = 1'b0;
    idle_pct                = 0;
    stall_pct               = 0;
    hold_len                = 0;
    req_ch.valid           <= 1'b0;
    req_ch.opcode          <= OP_INSERT;
    req_ch.priority_req    <= '0;
    req_ch.event_handle    <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pop on empty, extremes, fifo order within a level, pop fields ignored
    send_item(OP_POP,    4'd0,  32'h0000_0000);
    send_item(OP_INSERT, 4'd15, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 4'd0,  32'h0000_0000);
    send_item(OP_INSERT, 4'd15, 32'h0000_0001);
    send_item(OP_INSERT, 4'd0,  32'hFFFF_FFFF);
    send_item(OP_INSERT, 4'd8,  32'hA5A5_A5A5);
    send_item(OP_INSERT, 4'd0,  32'h5A5A_5A5A);
    for (int i = 0; i < 7; i++) send_item(OP_POP, 4'd15, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 4'd3,  32'h1234_5678);
    send_item(OP_POP,    4'd9,  32'h8765_4321);
    send_item(OP_POP,    4'd0,  32'h0000_0000);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 85; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 85; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      run_random(500, (phase == 0) ? 250 : -1, (phase == 1) ? 200 : -1);
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (fail_total == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
